>>> rtl/lspa_pkg.sv
package lspa_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;
    localparam int LIST_CAP = 32;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_WR,
        ST_FREE_WALK,
        ST_FREE_UNLINK,
        ST_FREE_PUSH,
        ST_LIST_EMIT
    } lspa_state_t;

endpackage

>>> rtl/lspa_link_mem.sv
module lspa_link_mem
    import lspa_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int IDX_W  = 5,
    parameter int LINK_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [LINK_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [LINK_W-1:0] wr_data
);

    logic [LINK_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [LINK_W-1:0] data_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  addr_reg;

    // unwritten entries read as the reset chain: link of slot i is i+1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
            addr_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg  <= written_reg[rd_addr];
                addr_reg <= rd_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : (LINK_W'(addr_reg) + LINK_W'(1));

endmodule

>>> rtl/linked_slot_pool_allocator.sv
// allocate: a free-head read, then ALLOC_WR links the slot in and registers the result (from idle if exhausted)
// free: walks the active list one hop a cycle, then FREE_UNLINK and FREE_PUSH move the slot to the free list
// list: a head read, then LIST_EMIT registers one result per cycle
// busy is low again in the cycle the final result shows; the receiver cannot stall
// asynchronous active-low reset empties the active list; the link table reads as
//   the initial free chain at once through per-entry written flags
module linked_slot_pool_allocator
    import lspa_pkg::*;
#(
    parameter int POOL_SIZE = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     slot_id,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     result_id,
    output logic                last
);

    localparam int LINK_W   = $clog2(POOL_SIZE + 1);
    localparam int IDX_W    = $clog2(POOL_SIZE);
    localparam int CMP_W    = (LINK_W > ID_W) ? LINK_W : ID_W;
    localparam int LIST_LIM = (POOL_SIZE < LIST_CAP) ? POOL_SIZE : LIST_CAP;
    localparam logic [LINK_W-1:0] NIL     = LINK_W'(POOL_SIZE);
    localparam logic [LINK_W:0]   LIM_VAL = (LINK_W + 1)'(LIST_LIM);

    lspa_state_t state_reg, state_next;

    logic [LINK_W-1:0]   active_head_reg, active_head_next;
    logic [LINK_W-1:0]   free_head_reg, free_head_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    logic [LINK_W-1:0]   cnt_reg, cnt_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                first_reg, first_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     result_id_reg, result_id_next;
    logic                last_reg, last_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;

    logic [LINK_W-1:0] cand;
    logic [LINK_W:0]   cnt_inc;
    logic              list_end;

    function automatic logic [ID_W-1:0] low_id(input logic [LINK_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return w[ID_W-1:0];
    endfunction

    lspa_link_mem #(
        .DEPTH  (POOL_SIZE),
        .IDX_W  (IDX_W),
        .LINK_W (LINK_W)
    ) u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign cand     = first_reg ? cur_reg : rd_data;
    assign cnt_inc  = {1'b0, cnt_reg} + (LINK_W + 1)'(1);
    assign list_end = (rd_data >= NIL) || (cnt_inc == LIM_VAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_head_reg <= NIL;
            free_head_reg   <= '0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            steps_reg       <= '0;
            cnt_reg         <= '0;
            id_reg          <= '0;
            first_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STAT_OK;
            result_id_reg   <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_head_reg <= active_head_next;
            free_head_reg   <= free_head_next;
            cur_reg         <= cur_next;
            prev_reg        <= prev_next;
            steps_reg       <= steps_next;
            cnt_reg         <= cnt_next;
            id_reg          <= id_next;
            first_reg       <= first_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            result_id_reg   <= result_id_next;
            last_reg        <= last_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        active_head_next = active_head_reg;
        free_head_next   = free_head_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        steps_next       = steps_reg;
        cnt_next         = cnt_reg;
        id_next          = id_reg;
        first_next       = first_reg;
        out_valid_next   = 1'b0;
        status_next      = status_reg;
        result_id_next   = result_id_reg;
        last_next        = last_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    id_next = slot_id;
                    priority if (func == FUNC_ALLOC)
                    begin
                        if (free_head_reg >= NIL)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STAT_EXHAUSTED;
                            result_id_next = '0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = free_head_reg[IDX_W-1:0];
                            state_next = ST_ALLOC_WR;
                        end
                    end
                    else if (func == FUNC_FREE)
                    begin
                        if (active_head_reg >= NIL)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STAT_EMPTY;
                            result_id_next = slot_id;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            cur_next   = active_head_reg;
                            prev_next  = NIL;
                            steps_next = '0;
                            first_next = 1'b1;
                            state_next = ST_FREE_WALK;
                        end
                    end
                    else if (func == FUNC_LIST)
                    begin
                        if (active_head_reg >= NIL)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STAT_EMPTY;
                            result_id_next = '0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = active_head_reg[IDX_W-1:0];
                            cur_next   = active_head_reg;
                            cnt_next   = '0;
                            state_next = ST_LIST_EMIT;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ALLOC_WR:
            begin
                wr_en            = 1'b1;
                wr_addr          = free_head_reg[IDX_W-1:0];
                wr_data          = active_head_reg;
                active_head_next = free_head_reg;
                free_head_next   = rd_data;
                out_valid_next   = 1'b1;
                status_next      = STAT_OK;
                result_id_next   = low_id(free_head_reg);
                last_next        = 1'b1;
                state_next       = ST_IDLE;
            end

            ST_FREE_WALK:
            begin
                first_next = 1'b0;
                priority if ((cand >= NIL) || (steps_reg >= NIL))
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_NOT_FOUND;
                    result_id_next = id_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (CMP_W'(cand) == CMP_W'(id_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cand[IDX_W-1:0];
                    cur_next   = cand;
                    state_next = ST_FREE_UNLINK;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cand[IDX_W-1:0];
                    prev_next  = cand;
                    steps_next = steps_reg + LINK_W'(1);
                end
            end

            ST_FREE_UNLINK:
            begin
                if (prev_reg >= NIL)
                begin
                    active_head_next = rd_data;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[IDX_W-1:0];
                    wr_data = rd_data;
                end
                state_next = ST_FREE_PUSH;
            end

            ST_FREE_PUSH:
            begin
                wr_en          = 1'b1;
                wr_addr        = cur_reg[IDX_W-1:0];
                wr_data        = free_head_reg;
                free_head_next = cur_reg;
                out_valid_next = 1'b1;
                status_next    = STAT_OK;
                result_id_next = low_id(cur_reg);
                last_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_LIST_EMIT:
            begin
                out_valid_next = 1'b1;
                status_next    = STAT_OK;
                result_id_next = low_id(cur_reg);
                last_next      = list_end;
                if (list_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data[IDX_W-1:0];
                    cur_next = rd_data;
                    cnt_next = cnt_inc[LINK_W-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign result_id = result_id_reg;
    assign last      = last_reg;

endmodule

>>> rtl/lspa_checker.sv
module lspa_checker
    import lspa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                busy,
    input logic                out_valid,
    input logic [STATUS_W-1:0] status,
    input logic                last
);

    // the final beat of an item frees the block
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !busy)
        else $error("busy still high on final beat");

    // more beats pending keeps the block busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> busy)
        else $error("not busy while beats pending");

    // list beats come back to back
    a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("gap inside list burst");

    // any error ends the item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> last)
        else $error("error beat not final");

endmodule

bind linked_slot_pool_allocator lspa_checker u_lspa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .last      (last)
);

>>> dv/tb_linked_slot_pool_allocator.sv
`timescale 1ns / 100ps

module tb_linked_slot_pool_allocator;
    import lspa_pkg::*;

    localparam int POOL_SIZE = 32;
    localparam logic [5:0] NIL_LINK = 6'(POOL_SIZE);
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic                last;
    } slot_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [FUNC_W-1:0]   func = '0;
    logic [ID_W-1:0]     slot_id = '0;
    logic                busy;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic                last;

    logic [5:0] mdl_link [0:POOL_SIZE-1];
    logic [5:0] mdl_active_head;
    logic [5:0] mdl_free_head;
    slot_beat_t expected_beats[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit use_gaps = 1'b1;

    linked_slot_pool_allocator #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .slot_id(slot_id),
        .out_valid(out_valid),
        .status(status),
        .result_id(result_id),
        .last(last)
    );

    always #1 clk = ~clk;

    function automatic void reset_pool_model();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            mdl_link[i] = (i + 1 < POOL_SIZE) ? 6'(i + 1) : NIL_LINK;
        end
        mdl_active_head = NIL_LINK;
        mdl_free_head = 6'd0;
    endfunction

    function automatic void expect_beat(logic [STATUS_W-1:0] st, logic [5:0] id, logic lst);
        slot_beat_t b;
        b.status = st;
        b.id = id[ID_W-1:0];
        b.last = lst;
        expected_beats.push_back(b);
    endfunction

    function automatic void predict_pool_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id);
        logic [5:0] cur;
        logic [5:0] prev;
        int steps;
        case (f)
            FUNC_ALLOC:
            begin
                if (mdl_free_head == NIL_LINK)
                begin
                    expect_beat(STAT_EXHAUSTED, 6'd0, 1'b1);
                end
                else
                begin
                    cur = mdl_free_head;
                    mdl_free_head = mdl_link[cur];
                    mdl_link[cur] = mdl_active_head;
                    mdl_active_head = cur;
                    expect_beat(STAT_OK, cur, 1'b1);
                end
            end
            FUNC_FREE:
            begin
                if (mdl_active_head == NIL_LINK)
                begin
                    expect_beat(STAT_EMPTY, {1'b0, id}, 1'b1);
                end
                else
                begin
                    prev = NIL_LINK;
                    cur = mdl_active_head;
                    steps = 0;
                    while (cur != NIL_LINK && steps < POOL_SIZE && cur != {1'b0, id})
                    begin
                        prev = cur;
                        cur = mdl_link[cur];
                        steps++;
                    end
                    if (cur == NIL_LINK || steps >= POOL_SIZE)
                    begin
                        expect_beat(STAT_NOT_FOUND, {1'b0, id}, 1'b1);
                    end
                    else
                    begin
                        if (prev == NIL_LINK)
                            mdl_active_head = mdl_link[cur];
                        else
                            mdl_link[prev] = mdl_link[cur];
                        mdl_link[cur] = mdl_free_head;
                        mdl_free_head = cur;
                        expect_beat(STAT_OK, cur, 1'b1);
                    end
                end
            end
            FUNC_LIST:
            begin
                if (mdl_active_head == NIL_LINK)
                begin
                    expect_beat(STAT_EMPTY, 6'd0, 1'b1);
                end
                else
                begin
                    cur = mdl_active_head;
                    steps = 0;
                    while (cur != NIL_LINK && steps < LIST_CAP && steps < POOL_SIZE)
                    begin
                        expect_beat(STAT_OK, cur,
                                    mdl_link[cur] == NIL_LINK || steps + 1 == LIST_CAP);
                        cur = mdl_link[cur];
                        steps++;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_active_slot();
        logic [5:0] cur;
        logic [ID_W-1:0] ids[$];
        cur = mdl_active_head;
        while (cur != NIL_LINK && ids.size() < POOL_SIZE)
        begin
            ids.push_back(cur[ID_W-1:0]);
            cur = mdl_link[cur];
        end
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id);
        int gap;
        gap = use_gaps ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        func <= f;
        slot_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_pool_op(f, id);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
    endtask

    // one result beat per strobe, compared with the oldest expectation
    always @(posedge clk)
    begin
        slot_beat_t exp_b;
        if (rst_n && out_valid)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: beat expected none actual status %0d id %0d last %0d",
                         $time, status, result_id, last);
            end
            else
            begin
                exp_b = expected_beats.pop_front();
                if (status !== exp_b.status)
                    note_mismatch("status", exp_b.status, status);
                if (result_id !== exp_b.id)
                    note_mismatch("result_id", exp_b.id, result_id);
                if (last !== exp_b.last)
                    note_mismatch("last", exp_b.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_empty_pool();
        send_cmd(FUNC_LIST, 5'd0);
        send_cmd(FUNC_FREE, 5'd31);
        send_cmd(FUNC_FREE, 5'd0);
        send_cmd(FUNC_NONE, 5'd21);
    endtask

    task automatic test_exhaust_and_list();
        for (int i = 0; i < POOL_SIZE; i++)
            send_cmd(FUNC_ALLOC, 5'($urandom));
        send_cmd(FUNC_ALLOC, 5'd31);
        send_cmd(FUNC_LIST, 5'd10);
        send_cmd(FUNC_NONE, 5'd0);
    endtask

    task automatic test_free_cases();
        send_cmd(FUNC_FREE, 5'd15);
        send_cmd(FUNC_FREE, 5'd15);
        send_cmd(FUNC_FREE, 5'd31);
        send_cmd(FUNC_FREE, 5'd0);
        send_cmd(FUNC_FREE, 5'd31);
        send_cmd(FUNC_ALLOC, 5'd0);
        send_cmd(FUNC_LIST, 5'd31);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int alloc_pct;
        int r;
        for (int round = 0; round < 10; round++)
        begin
            use_gaps = (round % 3 != 1);
            alloc_pct = (round % 2 == 0) ? 60 : 25;
            for (int k = 0; k < 50; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < alloc_pct)
                begin
                    send_cmd(FUNC_ALLOC, 5'($urandom));
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65 && mdl_active_head != NIL_LINK)
                        send_cmd(FUNC_FREE, pick_active_slot());
                    else if (r < 80)
                        send_cmd(FUNC_FREE, 5'($urandom));
                    else if (r < 95)
                        send_cmd(FUNC_LIST, 5'($urandom));
                    else
                        send_cmd(FUNC_NONE, 5'($urandom));
                end
            end
            if (round == 4)
                wait_results_drained();
        end
    endtask

    initial
    begin
        reset_pool_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_pool();
        test_exhaust_and_list();
        test_free_cases();
        test_random_traffic();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/lspa_pkg.sv
rtl/lspa_link_mem.sv
rtl/linked_slot_pool_allocator.sv
rtl/lspa_checker.sv
dv/tb_linked_slot_pool_allocator.sv
